// ----- sv/csb_pkg.sv -----
`default_nettype none
package csb_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_BITS = 64;

   // port widths fixed by the interface
   localparam int MODE_W = 2;
   localparam int DATA_W = 64;
   localparam int DIST_W = 7;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 6;
   localparam int CFG_W  = 7;

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = ((DIST_W > SIZE_W) ? DIST_W : SIZE_W) + 1;

   localparam int RING_SIZE_RST = 64;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_PEEK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [SLOT_BITS-1:0] data;
      logic [DIST_W-1:0]    peek_dist;
   } cmd_type;

endpackage
`default_nettype wire

// ----- sv/circular_slot_buffer_unit.sv -----
`default_nettype none
// channel   handshake               word
// req       req_push / req_full     req_mode, req_write_data, req_peek_distance
// rsp       rsp_pop / rsp_empty     rsp_status, rsp_read_data, rsp_occupancy
// csr       csr_valid / csr_ready   csr_ring_size
//
// A word is registered into the two-entry command queue, then passes the
// executor: pointer update plus slot RAM access, then the RAM read
// register feeding the result register. The executor takes the next word once
// the result register is free or popped in that cycle, never while filling a result.
// Synchronous reset clears pointers and count; slots are not cleared.
// A held result stalls the executor; a full queue raises req_full.
module circular_slot_buffer_unit import csb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic [DIST_W-1:0] req_peek_distance,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [OCC_W-1:0]       rsp_occupancy,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CFG_W-1:0]  csr_ring_size
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   csb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_write_data    (req_write_data),
      .req_peek_distance (req_peek_distance),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   csb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .csr_valid     (csr_valid && csr_ready),
      .csr_ring_size (csr_ring_size),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data),
      .rsp_occupancy (rsp_occupancy)
   );

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> (rsp_read_data == '0))
      else $error("failed operation carries read data");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> cmd_valid)
      else $error("accepted word missing from command queue");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("executor took a command from an empty queue");

endmodule
`default_nettype wire

// ----- sv/csb_front.sv -----
`default_nettype none
module csb_front import csb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic [DIST_W-1:0] req_peek_distance,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  wire logic              cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   cmd_type    cmd_in;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      case (req_mode)
         MODE_ADD:    cmd_in.op = OP_ADD;
         MODE_REMOVE: cmd_in.op = OP_REMOVE;
         MODE_PEEK:   cmd_in.op = OP_PEEK;
         default:     cmd_in.op = OP_NOP;
      endcase
      cmd_in.data      = SLOT_BITS'(req_write_data);
      cmd_in.peek_dist = req_peek_distance;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/csb_back.sv -----
`default_nettype none
module csb_back import csb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd,
   output logic                   cmd_pop,
   input  wire logic              csr_valid,
   input  wire logic [CFG_W-1:0]  csr_ring_size,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [OCC_W-1:0]       rsp_occupancy
);

   typedef enum logic {
      S_IDLE,
      S_FILL
   } state_type;

   state_type            state_ff;
   logic [SLOT_BITS-1:0] mem [MAX_SLOTS];
   logic [SLOT_BITS-1:0] mem_q_ff;

   logic [IDX_W-1:0]  wi_ff, ri_ff, cnt_ff;
   logic [IDX_W-1:0]  wi_in, ri_in, cnt_in;
   logic [SIZE_W-1:0] size_ff;

   logic              res_valid_ff;
   logic              res_keep_ff;
   logic [STAT_W-1:0] res_status_ff;
   logic [DATA_W-1:0] res_data_ff;
   logic [OCC_W-1:0]  res_occ_ff;

   logic              do_exec;
   logic              wr_en, rd_en, keep;
   logic [IDX_W-1:0]  addr;
   logic [STAT_W-1:0] st;
   logic [CMP_W-1:0]  pos_w;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [CFG_W:0] vw;
      vw = {1'b0, v};
      if (vw < (CFG_W+1)'(2)) begin
         return SIZE_W'(2);
      end else if (vw > (CFG_W+1)'(MAX_SLOTS)) begin
         return SIZE_W'(MAX_SLOTS);
      end else begin
         return SIZE_W'(v);
      end
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [SIZE_W-1:0] s);
      logic [CMP_W-1:0] sum;
      sum = CMP_W'(i) + CMP_W'(1);
      return (sum >= CMP_W'(s)) ? '0 : IDX_W'(sum);
   endfunction

   assign do_exec = (state_ff == S_IDLE) && cmd_valid && (!res_valid_ff || rsp_pop);
   assign cmd_pop = do_exec;

   // peek slot: write index minus distance, wrapped on the ring size
   assign pos_w = (CMP_W'(wi_ff) >= CMP_W'(cmd.peek_dist))
                ? (CMP_W'(wi_ff) - CMP_W'(cmd.peek_dist))
                : (CMP_W'(wi_ff) + CMP_W'(size_ff) - CMP_W'(cmd.peek_dist));

   always_comb begin
      st     = ST_OK;
      keep   = 1'b0;
      wr_en  = 1'b0;
      rd_en  = 1'b0;
      addr   = wi_ff;
      wi_in  = wi_ff;
      ri_in  = ri_ff;
      cnt_in = cnt_ff;
      case (cmd.op)
         OP_ADD: begin
            if ((CMP_W'(cnt_ff) + CMP_W'(1)) >= CMP_W'(size_ff)) begin
               st = ST_FULL;
            end else begin
               wr_en  = do_exec;
               wi_in  = next_idx(wi_ff, size_ff);
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         OP_REMOVE: begin
            if (cnt_ff == '0) begin
               st = ST_EMPTY;
            end else begin
               rd_en  = do_exec;
               keep   = 1'b1;
               addr   = ri_ff;
               ri_in  = next_idx(ri_ff, size_ff);
               cnt_in = cnt_ff - IDX_W'(1);
            end
         end
         OP_PEEK: begin
            if (cmd.peek_dist == '0 || CMP_W'(cmd.peek_dist) > CMP_W'(cnt_ff)) begin
               st = ST_RANGE;
            end else begin
               rd_en = do_exec;
               keep  = 1'b1;
               addr  = IDX_W'(pos_w);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= cmd.data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
         wi_ff        <= '0;
         ri_ff        <= '0;
         cnt_ff       <= '0;
         size_ff      <= clamp_size(CFG_W'(RING_SIZE_RST));
      end else begin
         if (rsp_pop && res_valid_ff) begin
            res_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            size_ff <= clamp_size(csr_ring_size);
            wi_ff   <= '0;
            ri_ff   <= '0;
            cnt_ff  <= '0;
         end else if (do_exec) begin
            wi_ff  <= wi_in;
            ri_ff  <= ri_in;
            cnt_ff <= cnt_in;
         end
         case (state_ff)
            S_IDLE: begin
               if (do_exec) begin
                  res_status_ff <= st;
                  res_occ_ff    <= OCC_W'(cnt_in);
                  res_keep_ff   <= keep;
                  state_ff      <= S_FILL;
               end
            end
            S_FILL: begin
               // memory word is out of the read register now
               res_data_ff  <= res_keep_ff ? DATA_W'(mem_q_ff) : '0;
               res_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty     = !res_valid_ff;
   assign rsp_status    = res_status_ff;
   assign rsp_read_data = res_data_ff;
   assign rsp_occupancy = res_occ_ff;

endmodule
`default_nettype wire

// ----- sim/circular_slot_buffer_unit_tb.sv -----
`default_nettype none
module circular_slot_buffer_unit_tb;
   import csb_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 150;
   localparam int RX_HOLD       = 300;
   localparam int REPORT_CAP    = 40;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] data;
      logic [OCC_W-1:0]  occ;
   } slot_result_type;

   typedef enum {ROW_WORD, ROW_SIZE} row_kind_type;
   typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_type;

   typedef struct {
      row_kind_type      kind;
      op_type            op;
      logic [DATA_W-1:0] data;
      logic [DIST_W-1:0] peek_dist;
      bit                typed;
      slot_result_type   res;
   } step_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [MODE_W-1:0]   req_mode;
   logic [DATA_W-1:0]   req_write_data;
   logic [DIST_W-1:0]   req_peek_distance;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [STAT_W-1:0]   rsp_status;
   logic [DATA_W-1:0]   rsp_read_data;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_ring_size;

   circular_slot_buffer_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_write_data    (req_write_data),
      .req_peek_distance (req_peek_distance),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_occupancy     (rsp_occupancy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_ring_size     (csr_ring_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ring copy kept in step with accepted words
   logic [SLOT_BITS-1:0] slot_copy [MAX_SLOTS];
   int                   head_idx;
   int                   tail_idx;
   int                   fill_count;
   int                   size_reg;

   slot_result_type pending_results [$];
   step_row_type    directed_steps [$];
   int              mismatch_count;
   int              tx_idle_pct;
   int              rx_idle_pct;
   int              rsp_hold_left;

   task automatic ring_apply(input op_type op, input logic [DATA_W-1:0] wdata,
                             input logic [DIST_W-1:0] peek_dist,
                             output slot_result_type r);
      int s;
      int pos;
      int d;
      d = int'(peek_dist);
      s = (size_reg < 2) ? 2 : ((size_reg > MAX_SLOTS) ? MAX_SLOTS : size_reg);
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_ADD: begin
            if (fill_count >= s - 1) begin
               r.status = ST_FULL;
            end else begin
               slot_copy[head_idx] = wdata[SLOT_BITS-1:0];
               head_idx = (head_idx + 1 >= s) ? 0 : head_idx + 1;
               fill_count++;
            end
         end
         OP_REMOVE: begin
            if (fill_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = DATA_W'(slot_copy[tail_idx]);
               tail_idx = (tail_idx + 1 >= s) ? 0 : tail_idx + 1;
               fill_count--;
            end
         end
         OP_PEEK: begin
            if (d == 0 || d > fill_count) begin
               r.status = ST_RANGE;
            end else begin
               pos = (head_idx >= d) ? head_idx - d : head_idx + s - d;
               r.data = DATA_W'(slot_copy[pos]);
            end
         end
         default: ;
      endcase
      r.occ = fill_count[OCC_W-1:0];
   endtask

   task automatic add_row(input row_kind_type kind, input op_type op,
                          input logic [DATA_W-1:0] data,
                          input logic [DIST_W-1:0] peek_dist,
                          input bit typed, input logic [STAT_W-1:0] st,
                          input logic [DATA_W-1:0] rd, input logic [OCC_W-1:0] occ);
      step_row_type row;
      row.kind       = kind;
      row.op         = op;
      row.data       = data;
      row.peek_dist  = peek_dist;
      row.typed      = typed;
      row.res.status = st;
      row.res.data   = rd;
      row.res.occ    = occ;
      directed_steps.push_back(row);
   endtask

   // called and returns at a falling edge
   task automatic send_word(input op_type op, input logic [DATA_W-1:0] data,
                            input logic [DIST_W-1:0] peek_dist, input bit typed,
                            input slot_result_type typed_res);
      slot_result_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push          <= 1'b1;
      req_mode          <= op;
      req_write_data    <= data;
      req_peek_distance <= peek_dist;
      @(posedge clock);
      while (req_full) @(posedge clock);
      ring_apply(op, data, peek_dist, r);
      pending_results.push_back(typed ? typed_res : r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ring_size(input logic [CFG_W-1:0] value);
      drain();
      csr_valid     <= 1'b1;
      csr_ring_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_reg   = int'(value);
      head_idx   = 0;
      tail_idx   = 0;
      fill_count = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always begin
      @(negedge clock);
      if (rsp_hold_left > 0) begin
         rsp_pop <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic void report_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
      if (mismatch_count < REPORT_CAP)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin
      slot_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < REPORT_CAP)
               $display("%0t: unexpected word, expected none, actual %h %h %h", $time,
                        rsp_status, rsp_read_data, rsp_occupancy);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
            if (rsp_read_data !== want.data)
               report_field("read_data", want.data, rsp_read_data);
            if (rsp_occupancy !== want.occ)
               report_field("occupancy", DATA_W'(want.occ), DATA_W'(rsp_occupancy));
         end
      end
   end

   initial begin
      int cyc;
      for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clock);
      $display("circular_slot_buffer_unit_tb failed");
      $finish;
   end

   initial begin
      int size_plan [9] = '{64, 2, 127, 1, 65, 3, 0, 40, 64};
      logic [DATA_W-1:0] ones;
      logic [DATA_W-1:0] data;
      logic [DIST_W-1:0] peek_dist;
      slot_result_type   none;
      op_type            op;
      lean_type          lean;
      int                seg_left;
      int                pick;
      int                ph;
      int                n;

      ones              = '1;
      none              = '0;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_mode          = '0;
      req_write_data    = '0;
      req_peek_distance = '0;
      rsp_pop           = 1'b0;
      csr_valid         = 1'b0;
      csr_ring_size     = '0;
      tx_idle_pct       = 36;
      rx_idle_pct       = 60;
      rsp_hold_left     = 0;
      mismatch_count    = 0;
      size_reg          = RING_SIZE_RST;
      head_idx          = 0;
      tail_idx          = 0;
      fill_count        = 0;
      seg_left          = 0;
      lean              = LEAN_EVEN;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ring of 64 after reset
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 1, ST_EMPTY, 0, 0);
      add_row(ROW_WORD, OP_PEEK, 0, 0, 1, ST_RANGE, 0, 0);
      add_row(ROW_WORD, OP_NOP, 0, 0, 1, ST_OK, 0, 0);
      add_row(ROW_WORD, OP_ADD, ones, 0, 1, ST_OK, 0, 1);
      add_row(ROW_WORD, OP_ADD, 0, 7'h7f, 1, ST_OK, 0, 2);
      add_row(ROW_WORD, OP_PEEK, 0, 1, 1, ST_OK, 0, 2);
      add_row(ROW_WORD, OP_PEEK, 0, 2, 1, ST_OK, ones, 2);
      add_row(ROW_WORD, OP_PEEK, 0, 3, 1, ST_RANGE, 0, 2);
      add_row(ROW_WORD, OP_PEEK, ones, 7'h7f, 1, ST_RANGE, 0, 2);
      add_row(ROW_WORD, OP_ADD, 64'h8000_0000_0000_0001, 7'h7f, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_NOP, ones, 7'h7f, 1, ST_OK, 0, 3);
      add_row(ROW_WORD, OP_REMOVE, ones, 0, 1, ST_OK, ones, 2);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 1, ST_OK, 0, 1);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 1, ST_EMPTY, 0, 0);
      // size 0 acts as a two-slot ring: one entry
      add_row(ROW_SIZE, OP_NOP, 0, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_ADD, 64'h5a5a_a5a5_5a5a_a5a5, 0, 1, ST_OK, 0, 1);
      add_row(ROW_WORD, OP_ADD, 64'h1234_5678_9abc_def0, 0, 1, ST_FULL, 0, 1);
      add_row(ROW_WORD, OP_PEEK, 0, 1, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_PEEK, 0, 2, 1, ST_RANGE, 0, 1);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_ADD, 64'h0f0f_0f0f_0f0f_0f0f, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_PEEK, 0, 1, 0, 0, 0, 0);
      // oversize acts as 64; the write also clears the pointers
      add_row(ROW_SIZE, OP_NOP, 7'h7f, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 1, ST_EMPTY, 0, 0);
      add_row(ROW_WORD, OP_ADD, 64'hdead_beef_0000_ffff, 0, 0, 0, 0, 0);
      add_row(ROW_WORD, OP_REMOVE, 0, 0, 0, 0, 0, 0);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_SIZE)
            write_ring_size(directed_steps[i].data[CFG_W-1:0]);
         else
            send_word(directed_steps[i].op, directed_steps[i].data,
                      directed_steps[i].peek_dist, directed_steps[i].typed,
                      directed_steps[i].res);
      end

      for (ph = 0; ph < 9; ph++) begin
         tx_idle_pct = (ph < 3) ? 36 : ((ph < 6) ? 60 : 0);
         rx_idle_pct = (ph < 3) ? 60 : ((ph < 6) ? 36 : 0);
         if (ph == 7)
            size_plan[ph] = $urandom_range(MAX_SLOTS, 2);
         write_ring_size(CFG_W'(size_plan[ph]));
         // long receiver stall while words keep coming: input must back up
         if (ph == 0 || ph == 6)
            rsp_hold_left = RX_HOLD;
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2 && ph % 3 == 1)
               drain();
            if (seg_left == 0) begin
               lean     = lean_type'($urandom_range(2));
               seg_left = $urandom_range(120, 20);
               if (ph == 0 && n == 0)
                  lean = LEAN_FILL;
            end
            seg_left--;
            pick = $urandom_range(99);
            case (lean)
               LEAN_FILL:  op = (pick < 70) ? OP_ADD : (pick < 85) ? OP_REMOVE :
                                (pick < 98) ? OP_PEEK : OP_NOP;
               LEAN_DRAIN: op = (pick < 15) ? OP_ADD : (pick < 70) ? OP_REMOVE :
                                (pick < 98) ? OP_PEEK : OP_NOP;
               default:    op = (pick < 40) ? OP_ADD : (pick < 75) ? OP_REMOVE :
                                (pick < 98) ? OP_PEEK : OP_NOP;
            endcase
            pick = $urandom_range(15);
            data = (pick == 0) ? '0 : (pick == 1) ? ones : {$urandom, $urandom};
            if (fill_count == 0 || $urandom_range(4) == 0)
               peek_dist = DIST_W'($urandom_range(127, 0));
            else
               peek_dist = DIST_W'($urandom_range(fill_count, 1));
            send_word(op, data, peek_dist, 0, none);
         end
      end

      drain();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("circular_slot_buffer_unit_tb passed");
      end else begin
         $display("circular_slot_buffer_unit_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/csb_pkg.sv
sv/csb_front.sv
sv/csb_back.sv
sv/circular_slot_buffer_unit.sv
sim/circular_slot_buffer_unit_tb.sv
